/* sv/srrw_pkg.sv */
// Shared definitions for the selective-repeat receive window.
// Holds field widths, command codes and ack length constants; no dependencies.
package srrw_pkg;

   localparam int unsigned WINDOW_LOG2_DEFAULT = 4;
   localparam int unsigned SEQ_W         = 16;
   localparam int unsigned ID_W          = 12;
   localparam int unsigned MASK_W        = 64;
   localparam int unsigned ACK_BYTES_W   = 4;
   localparam int unsigned ACK_MAX_BYTES = 10;
   localparam int unsigned ACK_HDR_BYTES = 2;

   typedef enum logic [2:0] {
      CMD_CONNECT = 3'd0,
      CMD_PACKET  = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_ACK     = 3'd3,
      CMD_CLOSE   = 3'd4,
      CMD_RESET   = 3'd5
   } cmd_type;

endpackage

/* sv/selective_repeat_receive_window.sv */
// Receive window of a selective-repeat link with a slot-walking sequencer; uses srrw_pkg.
// Steps: connect, close, release, reset, dropped packets and empty ack polls go to finish;
// a placed packet passes extend if beyond the window, place, advance if it was oldest-unacked
// and trim once input is closed; an ack reply walks the slots after oldest-unacked.
// One word at a time: busy stays high until the result strobe; the receiver cannot stall.
// Synchronous reset empties the window and clears the connection, done, end-of-stream and ack-pending flags.
module selective_repeat_receive_window #(
   parameter int unsigned WINDOW_LOG2 = srrw_pkg::WINDOW_LOG2_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_cmd,
   input  logic [srrw_pkg::ID_W-1:0]           req_packet_id,
   input  logic                                req_final_flag,
   input  logic [srrw_pkg::SEQ_W-1:0]          req_start_seq,
   output logic                                rsp_valid,
   output logic                                rsp_ack_due,
   output logic                                rsp_new_data,
   output logic                                rsp_window_moved,
   output logic [srrw_pkg::SEQ_W-1:0]          rsp_ack_seq,
   output logic [srrw_pkg::MASK_W-1:0]         rsp_skip_mask,
   output logic [srrw_pkg::ACK_BYTES_W-1:0]    rsp_ack_bytes,
   output logic                                rsp_head_ready,
   output logic                                rsp_head_final,
   output logic                                rsp_stream_ended
);

   localparam int unsigned CAP    = 1 << WINDOW_LOG2;
   localparam int unsigned FILL_W = WINDOW_LOG2 + 1;
   localparam int unsigned SEQ_W  = srrw_pkg::SEQ_W;
   localparam int unsigned ID_W   = srrw_pkg::ID_W;
   localparam int unsigned MASK_W = srrw_pkg::MASK_W;
   localparam int unsigned BIT_W  = $clog2(MASK_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXTEND,
      ST_PLACE,
      ST_ADVANCE,
      ST_TRIM,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type                       state_ff;
   logic                            connected_ff;
   logic [SEQ_W-1:0]                wb_ff;
   logic [FILL_W-1:0]               fill_ff;
   logic [SEQ_W-1:0]                ou_ff;
   logic [CAP-1:0]                  slot_recv_ff;
   logic [CAP-1:0]                  slot_fin_ff;
   logic                            peer_done_ff;
   logic                            self_done_ff;
   logic                            eos_ff;
   logic                            ack_pending_ff;

   logic [SEQ_W-1:0]                seq_ff;
   logic [FILL_W-1:0]               dist_ff;
   logic                            fin_ff;
   logic [SEQ_W-1:0]                p_ff;
   logic [BIT_W-1:0]                bit_ff;
   logic [MASK_W-1:0]               mask_ff;
   logic [SEQ_W-1:0]                aseq_ff;
   logic                            reply_ff;
   logic                            ack_due_ff;
   logic                            new_data_ff;
   logic                            moved_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_ack_due_ff;
   logic                            rsp_new_data_ff;
   logic                            rsp_moved_ff;
   logic [SEQ_W-1:0]                rsp_ack_seq_ff;
   logic [MASK_W-1:0]               rsp_mask_ff;
   logic [srrw_pkg::ACK_BYTES_W-1:0] rsp_bytes_ff;
   logic                            rsp_head_ready_ff;
   logic                            rsp_head_final_ff;
   logic                            rsp_eos_ff;

   logic [WINDOW_LOG2-1:0]          rd_addr;
   logic                            rd_recv;
   logic                            rd_fin;
   logic [ID_W-1:0]                 rel_in;
   logic [SEQ_W-1:0]                ou_off;
   logic [SEQ_W-1:0]                p_off;
   logic                            ou_in_win;
   logic                            p_in_win;
   logic [WINDOW_LOG2-1:0]          ext_idx;
   logic                            head_ready;
   logic [srrw_pkg::ACK_BYTES_W-1:0] bytes_in;

   function automatic logic [srrw_pkg::ACK_BYTES_W-1:0] trim_len(input logic [MASK_W-1:0] m);
      logic [srrw_pkg::ACK_BYTES_W-1:0] lo;
      lo = '0;
      for (int i = MASK_W / 8 - 1; i >= 0; i--) begin
         if (m[8*i +: 8] != 8'd0) begin
            lo = srrw_pkg::ACK_BYTES_W'(i);
         end
      end
      if (m == '0) begin
         return srrw_pkg::ACK_BYTES_W'(srrw_pkg::ACK_HDR_BYTES);
      end
      return srrw_pkg::ACK_BYTES_W'(srrw_pkg::ACK_MAX_BYTES) - lo;
   endfunction

   always_comb begin
      case (state_ff)
         ST_PLACE:   rd_addr = seq_ff[WINDOW_LOG2-1:0];
         ST_ADVANCE: rd_addr = ou_ff[WINDOW_LOG2-1:0];
         ST_WALK:    rd_addr = p_ff[WINDOW_LOG2-1:0];
         default:    rd_addr = wb_ff[WINDOW_LOG2-1:0];
      endcase
   end

   assign rd_recv    = slot_recv_ff[rd_addr];
   assign rd_fin     = slot_fin_ff[rd_addr];
   assign rel_in     = req_packet_id - wb_ff[ID_W-1:0];
   assign ou_off     = ou_ff - wb_ff;
   assign p_off      = p_ff - wb_ff;
   assign ou_in_win  = ou_off < SEQ_W'(fill_ff);
   assign p_in_win   = p_off < SEQ_W'(fill_ff);
   assign ext_idx    = wb_ff[WINDOW_LOG2-1:0] + fill_ff[WINDOW_LOG2-1:0];
   assign head_ready = connected_ff && (fill_ff != '0) && rd_recv;
   assign bytes_in   = reply_ff ? trim_len(mask_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         connected_ff   <= 1'b0;
         wb_ff          <= '0;
         fill_ff        <= '0;
         ou_ff          <= '0;
         slot_recv_ff   <= '0;
         slot_fin_ff    <= '0;
         peer_done_ff   <= 1'b0;
         self_done_ff   <= 1'b0;
         eos_ff         <= 1'b0;
         ack_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  ack_due_ff  <= 1'b0;
                  new_data_ff <= 1'b0;
                  moved_ff    <= 1'b0;
                  reply_ff    <= 1'b0;
                  aseq_ff     <= '0;
                  mask_ff     <= '0;
                  fin_ff      <= req_final_flag;
                  state_ff    <= ST_FINISH;
                  case (srrw_pkg::cmd_type'(req_cmd))
                     srrw_pkg::CMD_CONNECT: begin
                        wb_ff        <= req_start_seq;
                        ou_ff        <= req_start_seq;
                        fill_ff      <= '0;
                        connected_ff <= 1'b1;
                     end
                     srrw_pkg::CMD_PACKET: begin
                        seq_ff  <= wb_ff + SEQ_W'(rel_in);
                        dist_ff <= FILL_W'(rel_in);
                        if (connected_ff) begin
                           if (rel_in[ID_W-1]) begin
                              ack_pending_ff <= 1'b1;
                              ack_due_ff     <= 1'b1;
                           end else if (rel_in < ID_W'(fill_ff)) begin
                              state_ff <= ST_PLACE;
                           end else if (!peer_done_ff && rel_in < ID_W'(CAP)) begin
                              state_ff <= ST_EXTEND;
                           end
                        end
                     end
                     srrw_pkg::CMD_RELEASE: begin
                        if (head_ready) begin
                           wb_ff    <= wb_ff + SEQ_W'(1);
                           fill_ff  <= fill_ff - FILL_W'(1);
                           moved_ff <= 1'b1;
                           if (rd_fin) begin
                              eos_ff <= 1'b1;
                           end
                        end
                     end
                     srrw_pkg::CMD_ACK: begin
                        if (ack_pending_ff) begin
                           ack_pending_ff <= 1'b0;
                           reply_ff       <= 1'b1;
                           aseq_ff        <= ou_ff;
                           p_ff           <= ou_ff + SEQ_W'(1);
                           bit_ff         <= BIT_W'(MASK_W - 1);
                           state_ff       <= ST_WALK;
                        end
                     end
                     srrw_pkg::CMD_CLOSE: begin
                        self_done_ff <= 1'b1;
                        if (fill_ff != '0) begin
                           moved_ff <= 1'b1;
                           wb_ff    <= wb_ff + SEQ_W'(fill_ff);
                           fill_ff  <= '0;
                        end
                     end
                     srrw_pkg::CMD_RESET: begin
                        connected_ff   <= 1'b0;
                        wb_ff          <= '0;
                        fill_ff        <= '0;
                        ou_ff          <= '0;
                        peer_done_ff   <= 1'b0;
                        self_done_ff   <= 1'b0;
                        eos_ff         <= 1'b0;
                        ack_pending_ff <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_EXTEND: begin
               slot_recv_ff[ext_idx] <= 1'b0;
               slot_fin_ff[ext_idx]  <= 1'b0;
               fill_ff               <= fill_ff + FILL_W'(1);
               if (fill_ff == dist_ff) begin
                  state_ff <= ST_PLACE;
               end
            end
            ST_PLACE: begin
               if (!rd_recv) begin
                  slot_recv_ff[rd_addr] <= 1'b1;
                  slot_fin_ff[rd_addr]  <= fin_ff;
               end
               if (fin_ff) begin
                  peer_done_ff <= 1'b1;
               end
               ack_pending_ff <= 1'b1;
               ack_due_ff     <= 1'b1;
               if (seq_ff == ou_ff) begin
                  ou_ff    <= ou_ff + SEQ_W'(1);
                  state_ff <= ST_ADVANCE;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_ADVANCE: begin
               if (ou_in_win && rd_recv) begin
                  ou_ff <= ou_ff + SEQ_W'(1);
               end else if (self_done_ff) begin
                  state_ff <= ST_TRIM;
               end else begin
                  new_data_ff <= 1'b1;
                  state_ff    <= ST_FINISH;
               end
            end
            ST_TRIM: begin
               if (fill_ff != '0 && ou_off != '0 && !ou_off[SEQ_W-1]) begin
                  if (ou_off < SEQ_W'(fill_ff)) begin
                     wb_ff   <= ou_ff;
                     fill_ff <= fill_ff - FILL_W'(ou_off);
                  end else begin
                     wb_ff   <= wb_ff + SEQ_W'(fill_ff);
                     fill_ff <= '0;
                  end
               end
               state_ff <= ST_FINISH;
            end
            ST_WALK: begin
               if (p_in_win) begin
                  mask_ff[bit_ff] <= rd_recv;
                  p_ff            <= p_ff + SEQ_W'(1);
                  bit_ff          <= bit_ff - BIT_W'(1);
                  if (bit_ff == '0) begin
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               rsp_valid_ff      <= 1'b1;
               rsp_ack_due_ff    <= ack_due_ff;
               rsp_new_data_ff   <= new_data_ff;
               rsp_moved_ff      <= moved_ff;
               rsp_ack_seq_ff    <= aseq_ff;
               rsp_mask_ff       <= mask_ff;
               rsp_bytes_ff      <= bytes_in;
               rsp_head_ready_ff <= head_ready;
               rsp_head_final_ff <= head_ready && rd_fin;
               rsp_eos_ff        <= eos_ff;
               state_ff          <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ack_due      = rsp_ack_due_ff;
   assign rsp_new_data     = rsp_new_data_ff;
   assign rsp_window_moved = rsp_moved_ff;
   assign rsp_ack_seq      = rsp_ack_seq_ff;
   assign rsp_skip_mask    = rsp_mask_ff;
   assign rsp_ack_bytes    = rsp_bytes_ff;
   assign rsp_head_ready   = rsp_head_ready_ff;
   assign rsp_head_final   = rsp_head_final_ff;
   assign rsp_stream_ended = rsp_eos_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAP))
      else $error("window fill exceeds slot count");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(state_ff == ST_FINISH))
      else $error("result strobe not preceded by finish");

   a_final_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_head_final |-> rsp_head_ready)
      else $error("head final without head ready");

   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_bytes != '0 |->
         rsp_ack_bytes >= srrw_pkg::ACK_BYTES_W'(srrw_pkg::ACK_HDR_BYTES) &&
         rsp_ack_bytes <= srrw_pkg::ACK_BYTES_W'(srrw_pkg::ACK_MAX_BYTES))
      else $error("ack length out of range");

   a_walk_clears_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> !ack_pending_ff && reply_ff)
      else $error("ack walk with pending flag still set");

endmodule
